### hw/rtl/oahash_pkg.sv
package oahash_pkg;

    localparam int MAX_SLOTS      = 1024;
    localparam int SLOT_W         = $clog2(MAX_SLOTS);
    localparam int SIZE_W         = SLOT_W + 1;
    localparam int PRIME_W        = 10;
    localparam int SCHEME_W       = 2;
    localparam int KEY_W          = 31;
    localparam int PROBES_W       = 11;
    localparam int TOTAL_W        = 32;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 11;

    // remainder unit: dividend bits retired per cycle
    localparam int DIVIDEND_W     = 32;
    localparam int DIV_RADIX_BITS = 4;
    localparam int DIV_ROUNDS     = DIVIDEND_W / DIV_RADIX_BITS;
    localparam int DIV_ROUND_W    = $clog2(DIV_ROUNDS);

    localparam logic [CFG_IDX_W-1:0] CFG_SCHEME = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PRIME  = 2'd2;

    localparam logic [SCHEME_W-1:0] SCHEME_LINEAR    = 2'd0;
    localparam logic [SCHEME_W-1:0] SCHEME_QUADRATIC = 2'd1;
    localparam logic [SCHEME_W-1:0] SCHEME_DOUBLE    = 2'd2;

    localparam logic [SCHEME_W-1:0] RESET_SCHEME = SCHEME_LINEAR;
    localparam logic [SIZE_W-1:0]   RESET_SIZE   = 11'd1024;
    localparam logic [PRIME_W-1:0]  RESET_PRIME  = 10'd1021;

    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_CLEAR  = 1'b1;

    typedef struct packed {
        logic             mode;
        logic [KEY_W-1:0] key;
    } in_word_t;

    typedef struct packed {
        logic [SLOT_W-1:0]   slot;
        logic [PROBES_W-1:0] probes;
        logic [TOTAL_W-1:0]  total_collisions;
        logic                table_full;
    } out_word_t;

    typedef struct packed {
        logic              rd_en;
        logic [SLOT_W-1:0] rd_addr;
        logic              wr_en;
        logic [SLOT_W-1:0] wr_addr;
        logic              clear;
    } tbl_req_t;

endpackage

### hw/rtl/oahash_divider.sv
module oahash_divider
    import oahash_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [SIZE_W-1:0]     divisor,
    output logic                  done,
    output logic [SIZE_W-1:0]     remainder
);

    logic                   busy_reg;
    logic                   done_reg;
    logic [DIV_ROUND_W-1:0] round_reg;
    logic [DIVIDEND_W-1:0]  shift_reg;
    logic [SIZE_W-1:0]      rem_reg;
    logic [SIZE_W-1:0]      rem_next;
    logic [SIZE_W:0]        rem_w;

    // retire several dividend bits per cycle, restoring compare-subtract
    always_comb
    begin
        rem_w = {1'b0, rem_reg};
        for (int i = 0; i < DIV_RADIX_BITS; i++)
        begin
            rem_w = {rem_w[SIZE_W-1:0], shift_reg[DIVIDEND_W-1-i]};
            if (rem_w >= {1'b0, divisor})
            begin
                rem_w = rem_w - {1'b0, divisor};
            end
        end
        rem_next = rem_w[SIZE_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            round_reg <= '0;
        end
        else if (start)
        begin
            busy_reg  <= 1'b1;
            done_reg  <= 1'b0;
            round_reg <= '0;
        end
        else if (busy_reg)
        begin
            round_reg <= round_reg + 1'b1;
            if (round_reg == DIV_ROUND_W'(DIV_ROUNDS - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            shift_reg <= dividend;
            rem_reg   <= '0;
        end
        else if (busy_reg)
        begin
            shift_reg <= shift_reg << DIV_RADIX_BITS;
            rem_reg   <= rem_next;
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

### hw/rtl/oahash_table.sv
module oahash_table
    import oahash_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  tbl_req_t req,
    output logic     rd_data,
    output logic     busy
);

    logic              mem [MAX_SLOTS];
    logic              sweep_reg;
    logic [SLOT_W-1:0] sweep_cnt_reg;
    logic              rd_data_reg;

    // zero one slot per cycle after reset and on every clear
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sweep_reg     <= 1'b1;
            sweep_cnt_reg <= '0;
        end
        else if (req.clear)
        begin
            sweep_reg     <= 1'b1;
            sweep_cnt_reg <= '0;
        end
        else if (sweep_reg)
        begin
            sweep_cnt_reg <= sweep_cnt_reg + 1'b1;
            if (sweep_cnt_reg == SLOT_W'(MAX_SLOTS - 1))
            begin
                sweep_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (sweep_reg)
        begin
            mem[sweep_cnt_reg] <= 1'b0;
        end
        else if (req.wr_en)
        begin
            mem[req.wr_addr] <= 1'b1;
        end
        if (req.rd_en)
        begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
    assign busy    = sweep_reg;

endmodule

### hw/rtl/open_addressing_hash_insert_top.sv
// Channel   Direction  Handshake           Payload
// -------   ---------  ------------------  ----------------------------------
// in        input      in_valid/in_stall   in_word  (mode, key)
// out       output     out_valid/out_stall out_word (slot, probes, total, full)
// cfg       input      cfg_wr_en           cfg_index, cfg_data
//
// Insert: the home slot is the key modulo the size, then occupied slots are probed in turn
// until a free one is written or the table is full; double hashing adds a step-mod-size
// pass. The remainder units (4 bits a cycle) and one-read-per-cycle memory pace an insert.
// Reset and every clear word start a clearing pass over all 1024 slots of the memory;
// no input word is taken during it, configuration writes are taken as ever.
// A finished result waits in the output register; the next word is taken once it is loaded.
module open_addressing_hash_insert_top
    import oahash_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  in_word_t              in_word,
    output logic                  out_valid,
    input  logic                  out_stall,
    output out_word_t             out_word,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_DIV_HOME,
        ST_DIV_STEP,
        ST_PROBE,
        ST_FINISH
    } state_t;

    state_t                state_reg;

    // configuration
    logic [SCHEME_W-1:0]   scheme_reg;
    logic [SIZE_W-1:0]     size_reg;
    logic [PRIME_W-1:0]    prime_reg;

    // per-insert working registers
    logic [SLOT_W-1:0]     idx_reg;
    logic [SLOT_W-1:0]     delta_reg;
    logic [PROBES_W-1:0]   probes_reg;
    logic [TOTAL_W-1:0]    total_reg;
    logic [DIVIDEND_W-1:0] size_dividend_reg;
    logic [DIVIDEND_W-1:0] prime_dividend_reg;
    logic                  size_start_reg;
    logic                  prime_start_reg;
    out_word_t             res_reg;
    logic                  out_valid_reg;
    out_word_t             out_word_reg;

    logic [SIZE_W-1:0]     eff_size;
    logic [SIZE_W-1:0]     eff_prime;
    logic [SIZE_W-1:0]     step_w;
    logic [SIZE_W-1:0]     idx_sum;
    logic [SLOT_W-1:0]     idx_adv;
    logic [SIZE_W-1:0]     dq_sum;
    logic [SLOT_W-1:0]     delta_quad;
    logic [SLOT_W-1:0]     delta_first;
    logic [PROBES_W-1:0]   probes_inc;
    logic [PROBES_W-1:0]   probes_final;
    logic [TOTAL_W:0]      total_sum;
    logic [TOTAL_W-1:0]    total_sat;
    logic                  probe_free;
    logic                  probe_full;
    logic                  accept;
    logic                  out_load;

    logic                  size_done;
    logic [SIZE_W-1:0]     size_rem;
    logic                  prime_done;
    logic [SIZE_W-1:0]     prime_rem;

    tbl_req_t              tbl_req;
    logic                  tbl_rd_data;
    logic                  tbl_busy;

    oahash_divider u_size_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (size_start_reg),
        .dividend  (size_dividend_reg),
        .divisor   (eff_size),
        .done      (size_done),
        .remainder (size_rem)
    );

    oahash_divider u_prime_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (prime_start_reg),
        .dividend  (prime_dividend_reg),
        .divisor   (eff_prime),
        .done      (prime_done),
        .remainder (prime_rem)
    );

    oahash_table u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (tbl_req),
        .rd_data (tbl_rd_data),
        .busy    (tbl_busy)
    );

    // clamp the size into 1..MAX_SLOTS, a zero prime gives step 1
    always_comb
    begin
        if (size_reg == '0)
        begin
            eff_size = SIZE_W'(1);
        end
        else if (size_reg > SIZE_W'(MAX_SLOTS))
        begin
            eff_size = SIZE_W'(MAX_SLOTS);
        end
        else
        begin
            eff_size = size_reg;
        end
        eff_prime = (prime_reg == '0) ? SIZE_W'(1) : {1'b0, prime_reg};
    end

    // probe address arithmetic: the index and the offset stay below the size, so one
    // compare-subtract brings each sum back into range
    always_comb
    begin
        step_w      = eff_prime - prime_rem;
        idx_sum     = {1'b0, idx_reg} + {1'b0, delta_reg};
        idx_adv     = (idx_sum >= eff_size) ? SLOT_W'(idx_sum - eff_size)
                                            : idx_sum[SLOT_W-1:0];
        dq_sum      = {1'b0, delta_reg} + SIZE_W'(2);
        delta_quad  = (dq_sum >= eff_size) ? SLOT_W'(dq_sum - eff_size)
                                           : dq_sum[SLOT_W-1:0];
        // a one-slot table never advances, keep the offset in range anyway
        delta_first = (eff_size == SIZE_W'(1)) ? '0 : SLOT_W'(1);
        probes_inc  = probes_reg + 1'b1;
        probe_free  = (state_reg == ST_PROBE) && !tbl_rd_data;
        probe_full  = (state_reg == ST_PROBE) && tbl_rd_data
                      && (probes_inc == eff_size);
        probes_final = probe_free ? probes_reg : eff_size;
        total_sum   = {1'b0, total_reg} + (TOTAL_W + 1)'(probes_final);
        total_sat   = total_sum[TOTAL_W] ? '1 : total_sum[TOTAL_W-1:0];
    end

    assign in_stall = (state_reg != ST_IDLE) || tbl_busy;
    assign accept   = in_valid && !in_stall;
    assign out_load = (state_reg == ST_FINISH) && (!out_valid_reg || !out_stall);

    // table requests: read the home slot once it (and for double hashing the step) is known,
    // then the next probe address straight from the occupied check, write on a free slot, clear on a clear word
    always_comb
    begin
        tbl_req         = '0;
        tbl_req.clear   = accept && (in_word.mode == MODE_CLEAR);
        tbl_req.wr_en   = probe_free;
        tbl_req.wr_addr = idx_reg;
        case (state_reg)
            ST_DIV_HOME:
            begin
                tbl_req.rd_en   = size_done && (scheme_reg != SCHEME_DOUBLE);
                tbl_req.rd_addr = size_rem[SLOT_W-1:0];
            end
            ST_DIV_STEP:
            begin
                tbl_req.rd_en   = size_done;
                tbl_req.rd_addr = idx_reg;
            end
            ST_PROBE:
            begin
                tbl_req.rd_en   = tbl_rd_data && !probe_full;
                tbl_req.rd_addr = idx_adv;
            end
            default:
            begin
                tbl_req.rd_en   = 1'b0;
                tbl_req.rd_addr = '0;
            end
        endcase
    end

    // configuration writes, taken in any state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scheme_reg <= RESET_SCHEME;
            size_reg   <= RESET_SIZE;
            prime_reg  <= RESET_PRIME;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_SCHEME: scheme_reg <= cfg_data[SCHEME_W-1:0];
                CFG_SIZE:   size_reg   <= cfg_data[SIZE_W-1:0];
                CFG_PRIME:  prime_reg  <= cfg_data[PRIME_W-1:0];
                default:    ;
            endcase
        end
    end

    // sequencer and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= ST_IDLE;
            idx_reg            <= '0;
            delta_reg          <= '0;
            probes_reg         <= '0;
            total_reg          <= '0;
            size_dividend_reg  <= '0;
            prime_dividend_reg <= '0;
            size_start_reg     <= 1'b0;
            prime_start_reg    <= 1'b0;
            res_reg            <= '0;
            out_valid_reg      <= 1'b0;
            out_word_reg       <= '0;
        end
        else
        begin
            // kick both remainder units on an insert, the size unit again
            // for the double-hash step
            size_start_reg  <= (accept && (in_word.mode == MODE_INSERT))
                               || ((state_reg == ST_DIV_HOME) && size_done
                                   && (scheme_reg == SCHEME_DOUBLE));
            prime_start_reg <= accept && (in_word.mode == MODE_INSERT);
            if (out_valid_reg && !out_stall && !out_load)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        if (in_word.mode == MODE_CLEAR)
                        begin
                            total_reg <= '0;
                            res_reg   <= '0;
                            state_reg <= ST_CLEAR;
                        end
                        else
                        begin
                            size_dividend_reg  <= DIVIDEND_W'(in_word.key);
                            prime_dividend_reg <= DIVIDEND_W'(in_word.key);
                            state_reg          <= ST_DIV_HOME;
                        end
                    end
                end
                ST_CLEAR:
                begin
                    // the sweep flag rises the cycle after the clear request
                    if (!tbl_busy)
                    begin
                        state_reg <= ST_FINISH;
                    end
                end
                ST_DIV_HOME:
                begin
                    if (size_done)
                    begin
                        idx_reg    <= size_rem[SLOT_W-1:0];
                        probes_reg <= '0;
                        if (scheme_reg == SCHEME_DOUBLE)
                        begin
                            size_dividend_reg <= DIVIDEND_W'(step_w);
                            state_reg         <= ST_DIV_STEP;
                        end
                        else
                        begin
                            delta_reg <= delta_first;
                            state_reg <= ST_PROBE;
                        end
                    end
                end
                ST_DIV_STEP:
                begin
                    if (size_done)
                    begin
                        delta_reg <= size_rem[SLOT_W-1:0];
                        state_reg <= ST_PROBE;
                    end
                end
                ST_PROBE:
                begin
                    if (probe_free || probe_full)
                    begin
                        total_reg                <= total_sat;
                        res_reg.slot             <= probe_free ? idx_reg : '0;
                        res_reg.probes           <= probes_final;
                        res_reg.total_collisions <= total_sat;
                        res_reg.table_full       <= probe_full;
                        state_reg                <= ST_FINISH;
                    end
                    else
                    begin
                        // occupied: advance to the next probe position
                        probes_reg <= probes_inc;
                        idx_reg    <= idx_adv;
                        if (scheme_reg == SCHEME_QUADRATIC)
                        begin
                            delta_reg <= delta_quad;
                        end
                    end
                end
                ST_FINISH:
                begin
                    if (out_load)
                    begin
                        out_valid_reg <= 1'b1;
                        out_word_reg  <= res_reg;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

`ifndef SYNTHESIS
    // the probe position never leaves the slots in use
    a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PROBE) |-> ({1'b0, idx_reg} < eff_size))
        else $error("probe index outside table size");

    // both remainder units start together and must finish together on a key
    a_div_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
        prime_done |-> size_done)
        else $error("remainder units out of step");

    // a write ends the insert, so no read may be issued alongside it
    a_no_rd_on_wr: assert property (@(posedge clk) disable iff (!rst_n)
        tbl_req.wr_en |-> !tbl_req.rd_en)
        else $error("table read issued together with a write");

    // a result is loaded only from the finish state, and the block then idles
    a_finish_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> (state_reg == ST_IDLE) && out_valid_reg)
        else $error("result load did not return to idle");
`endif

endmodule
